FILE: hdl/sm4_pkg.sv
// Shared types, constants and functions for the SM4 block cipher.
// No dependencies; used by every module in hdl/.
package sm4_pkg;

   localparam int unsigned ROUNDS = 32;
   localparam int unsigned RND_W  = $clog2(ROUNDS);
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECRYPT_MODE = 2'd2;

   localparam logic [31:0] FK0 = 32'ha3b1bac6;
   localparam logic [31:0] FK1 = 32'h56aa3350;
   localparam logic [31:0] FK2 = 32'h677d9197;
   localparam logic [31:0] FK3 = 32'hb27022dc;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
      logic        block_last;
   } req_data_type;

   typedef struct packed {
      logic [63:0] out_high;
      logic [63:0] out_low;
      logic        result_last;
   } rsp_data_type;

   // Four working words of one block plus the batch flag.
   typedef struct packed {
      logic [31:0] x0;
      logic [31:0] x1;
      logic [31:0] x2;
      logic [31:0] x3;
      logic        last;
   } state_type;

   localparam logic [7:0] SBOX [256] = '{
      8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
      8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
      8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
      8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
      8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
      8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
      8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
      8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
      8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
      8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
      8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
      8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
      8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
      8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
      8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
      8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
      8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
      8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
      8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
      8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
      8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
      8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
      8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
      8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
      8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
      8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
      8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
      8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
      8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
      8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
      8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
      8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
   };

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] a);
      return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
   endfunction

   // CK byte j of round i is (4*i + j) * 7 mod 256.
   function automatic logic [31:0] ck_word(input logic [RND_W-1:0] idx);
      logic [31:0] w;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         w[31-8*j -: 8] = 8'({idx, 2'(j)}) * 8'd7;
      end
      return w;
   endfunction

   function automatic logic [31:0] lin_data(input logic [31:0] t);
      return t ^ rotl32(t, 2) ^ rotl32(t, 10) ^ rotl32(t, 18) ^ rotl32(t, 24);
   endfunction

   function automatic logic [31:0] lin_key(input logic [31:0] t);
      return t ^ rotl32(t, 13) ^ rotl32(t, 23);
   endfunction

endpackage

FILE: hdl/sm4_key_sched.sv
// Key registers and iterative round-key expansion, one round per cycle.
// Depends on sm4_pkg.
module sm4_key_sched (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         csr_we,
   input  logic [sm4_pkg::CSR_IDX_W-1:0]                csr_index,
   input  logic [63:0]                                  csr_wdata,
   output logic                                         busy,
   output logic [sm4_pkg::ROUNDS-1:0][31:0]             round_keys
);

   localparam logic [sm4_pkg::RND_W-1:0] LAST_RND = sm4_pkg::RND_W'(sm4_pkg::ROUNDS - 1);

   logic [63:0]                   key_high_ff;
   logic [63:0]                   key_low_ff;
   logic                          decrypt_ff;
   logic                          load_ff;
   logic                          run_ff;
   logic [sm4_pkg::RND_W-1:0]     count_ff;
   logic [31:0]                   x0_ff, x1_ff, x2_ff, x3_ff;
   logic [sm4_pkg::ROUNDS-1:0][31:0] rk_ff;

   logic                          csr_hit;
   logic [31:0]                   key_t;
   logic [31:0]                   key_in;
   logic [sm4_pkg::RND_W-1:0]     wr_idx;

   assign csr_hit = csr_we && (csr_index == sm4_pkg::CSR_KEY_HIGH ||
                               csr_index == sm4_pkg::CSR_KEY_LOW ||
                               csr_index == sm4_pkg::CSR_DECRYPT_MODE);

   assign key_t  = sm4_pkg::sub_word(x1_ff ^ x2_ff ^ x3_ff ^ sm4_pkg::ck_word(count_ff));
   assign key_in = x0_ff ^ sm4_pkg::lin_key(key_t);
   // decrypt stores in reverse order
   assign wr_idx = decrypt_ff ? (LAST_RND - count_ff) : count_ff;

   assign busy       = load_ff || run_ff;
   assign round_keys = rk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         decrypt_ff  <= 1'b0;
         load_ff     <= 1'b1;
         run_ff      <= 1'b0;
         count_ff    <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               sm4_pkg::CSR_KEY_HIGH:     key_high_ff <= csr_wdata;
               sm4_pkg::CSR_KEY_LOW:      key_low_ff  <= csr_wdata;
               sm4_pkg::CSR_DECRYPT_MODE: decrypt_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         if (csr_hit) begin
            load_ff <= 1'b1;
            run_ff  <= 1'b0;
         end else if (load_ff) begin
            load_ff  <= 1'b0;
            run_ff   <= 1'b1;
            count_ff <= '0;
         end else if (run_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == LAST_RND) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_ff) begin
         x0_ff <= key_high_ff[63:32] ^ sm4_pkg::FK0;
         x1_ff <= key_high_ff[31:0]  ^ sm4_pkg::FK1;
         x2_ff <= key_low_ff[63:32]  ^ sm4_pkg::FK2;
         x3_ff <= key_low_ff[31:0]   ^ sm4_pkg::FK3;
      end else if (run_ff) begin
         x0_ff <= x1_ff;
         x1_ff <= x2_ff;
         x2_ff <= x3_ff;
         x3_ff <= key_in;
         rk_ff[wr_idx] <= key_in;
      end
   end

endmodule

FILE: hdl/sm4_round_stage.sv
// One data round of SM4 with its pipeline register and stall logic.
// Depends on sm4_pkg.
module sm4_round_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  sm4_pkg::state_type  in_state,
   input  logic [31:0]         round_key,
   input  logic                hold_next,
   output logic                out_valid,
   output sm4_pkg::state_type  out_state,
   output logic                hold
);

   logic               valid_ff;
   sm4_pkg::state_type state_ff;
   sm4_pkg::state_type state_in;
   logic [31:0]        t;

   assign t = sm4_pkg::sub_word(in_state.x1 ^ in_state.x2 ^ in_state.x3 ^ round_key);

   always_comb begin
      state_in.x0   = in_state.x1;
      state_in.x1   = in_state.x2;
      state_in.x2   = in_state.x3;
      state_in.x3   = in_state.x0 ^ sm4_pkg::lin_data(t);
      state_in.last = in_state.last;
   end

   // a full stage holds only when the stage after it holds
   assign hold      = valid_ff && hold_next;
   assign out_valid = valid_ff;
   assign out_state = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!hold) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold && in_valid) begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/sm4_block_cipher.sv
// SM4 block cipher top level: key schedule plus a 32-stage round pipeline.
// Depends on sm4_pkg, sm4_key_sched and sm4_round_stage.
//
// Usage:
//  - Load key_high (index 0), key_low (index 1) and decrypt_mode (index 2)
//    through csr_we/csr_index/csr_wdata while no blocks are in flight.
//  - Each valid register write restarts round-key expansion (a load
//    step plus 32 key rounds, one per cycle in the key unit).
//    req_ready stays low during expansion and in the cycle of a write.
//  - Reset clears the key to zero in encrypt mode and runs the same
//    expansion before the first block is taken.
//  - Blocks enter on req_valid/req_ready. One round per register stage,
//    32 stages; the last stage is the output register on rsp_*.
//  - rsp_valid rises once an accepted block has passed every stage in order.
//  - Throughput: one block per cycle unless stalled, one round per stage.
//  - When rsp_ready is low the result holds; stages behind it keep
//    filling any empty slots, and req_ready drops only once the whole
//    pipe is full up to stage 0.
module sm4_block_cipher (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  sm4_pkg::req_data_type             req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sm4_pkg::rsp_data_type             rsp_data,
   input  logic                              csr_we,
   input  logic [sm4_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [63:0]                       csr_wdata
);

   localparam int unsigned NR = sm4_pkg::ROUNDS;

   logic                      ks_busy;
   logic [NR-1:0][31:0]       round_keys;
   logic [NR-1:0]             stage_valid;
   logic [NR-1:0]             stage_hold;
   logic [NR-1:0]             stage_hold_next;
   logic [NR-1:0]             stage_in_valid;
   sm4_pkg::state_type        stage_state    [NR];
   sm4_pkg::state_type        stage_in_state [NR];
   sm4_pkg::state_type        req_state;
   sm4_pkg::state_type        last_state;

   sm4_key_sched u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .busy       (ks_busy),
      .round_keys (round_keys)
   );

   assign req_ready = !stage_hold[0] && !ks_busy && !csr_we;

   always_comb begin
      req_state.x0   = req_data.block_high[63:32];
      req_state.x1   = req_data.block_high[31:0];
      req_state.x2   = req_data.block_low[63:32];
      req_state.x3   = req_data.block_low[31:0];
      req_state.last = req_data.block_last;
   end

   genvar k;
   generate
      for (k = 0; k < NR; k++) begin : g_stage
         if (k == 0) begin : g_first
            assign stage_in_valid[k] = req_valid && req_ready;
            assign stage_in_state[k] = req_state;
         end else begin : g_mid
            assign stage_in_valid[k] = stage_valid[k-1];
            assign stage_in_state[k] = stage_state[k-1];
         end
         if (k == NR - 1) begin : g_last
            assign stage_hold_next[k] = !rsp_ready;
         end else begin : g_inner
            assign stage_hold_next[k] = stage_hold[k+1];
         end

         sm4_round_stage u_round (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (stage_in_valid[k]),
            .in_state  (stage_in_state[k]),
            .round_key (round_keys[k]),
            .hold_next (stage_hold_next[k]),
            .out_valid (stage_valid[k]),
            .out_state (stage_state[k]),
            .hold      (stage_hold[k])
         );
      end
   endgenerate

   // final reverse of the four words
   assign last_state = stage_state[NR-1];
   assign rsp_valid  = stage_valid[NR-1];
   always_comb begin
      rsp_data.out_high    = {last_state.x3, last_state.x2};
      rsp_data.out_low     = {last_state.x1, last_state.x0};
      rsp_data.result_last = last_state.last;
   end

`ifndef SYNTHESIS
   // input stalls only when every stage is occupied
   assert property (@(posedge clock) disable iff (reset)
      stage_hold[0] |-> (&stage_valid))
      else $error("stage 0 held with a bubble in the pipe");

   // outside reset, expansion starts only after a register write
   assert property (@(posedge clock) disable iff (reset)
      $rose(ks_busy) |-> $past(csr_we))
      else $error("key expansion started without a write");

   // a new result must come from the stage before the output
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(stage_valid[NR-2]))
      else $error("result appeared without a predecessor");

   // no transfer into the pipe while round keys are being rebuilt
   assert property (@(posedge clock) disable iff (reset)
      ks_busy |=> !(stage_valid[0] && $past(stage_in_valid[0])))
      else $error("block entered during key expansion");
`endif

endmodule

FILE: verif/sm4_block_cipher_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sm4_block_cipher: ECB blocks checked against a
// behavioral SM4 key schedule and round function held in a scoreboard class.
// Depends on sm4_pkg (payload structs, register indexes) and the RTL in hdl/.
module sm4_block_cipher_tb;

   localparam int unsigned NUM_ROUNDS         = 32;
   localparam int unsigned TIMEOUT_CYCLES     = 200000;
   localparam int unsigned DRAIN_CYCLES       = 40;
   localparam int unsigned HOLDOFF_CYCLES     = 150;
   localparam int unsigned BLOCKS_PER_SEGMENT = 75;
   localparam int unsigned NUM_SEGMENTS       = 6;

   localparam logic [sm4_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam logic [63:0] MODE_ENCRYPT = 64'd0;
   localparam logic [63:0] MODE_DECRYPT = 64'd1;

   // published SM4 example: key and plaintext are the same 128 bits
   localparam logic [63:0] STD_KEY_HIGH = 64'h0123456789abcdef;
   localparam logic [63:0] STD_KEY_LOW  = 64'hfedcba9876543210;
   localparam logic [63:0] STD_CT_HIGH  = 64'h681edf34d206965e;
   localparam logic [63:0] STD_CT_LOW   = 64'h86b3e94f536e4246;

   localparam logic [31:0] FK_WORDS [4] = '{
      32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
   };

   localparam logic [7:0] SUBST_TABLE [256] = '{
      8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
      8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
      8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
      8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
      8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
      8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
      8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
      8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
      8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
      8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
      8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
      8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
      8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
      8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
      8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
      8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
      8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
      8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
      8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
      8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
      8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
      8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
      8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
      8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
      8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
      8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
      8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
      8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
      8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
      8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
      8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
      8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
   };

   // Tracks key/direction, expands round keys and queues the cipher blocks
   // that the block owes us, oldest first.
   class cipher_ledger;
      logic [63:0]           key_high;
      logic [63:0]           key_low;
      logic                  decrypt;
      logic [31:0]           round_key [NUM_ROUNDS];
      sm4_pkg::rsp_data_type owed_blocks [$];
      int unsigned           mismatches;

      function new();
         key_high   = '0;
         key_low    = '0;
         decrypt    = 1'b0;
         mismatches = 0;
         expand_keys();
      endfunction

      function logic [31:0] rol(logic [31:0] x, int unsigned n);
         return (x << n) | (x >> (32 - n));
      endfunction

      function logic [31:0] subst(logic [31:0] a);
         logic [31:0] r;
         for (int b = 0; b < 4; b++) r[8*b +: 8] = SUBST_TABLE[a[8*b +: 8]];
         return r;
      endfunction

      // byte j of CK[i] is (4*i + j) * 7 mod 256, MSB first
      function logic [31:0] ck_const(int unsigned i);
         logic [31:0] w;
         w = '0;
         for (int unsigned j = 0; j < 4; j++) w = {w[23:0], 8'((4 * i + j) * 7)};
         return w;
      endfunction

      function void expand_keys();
         logic [31:0] x [4];
         logic [31:0] t;
         logic [31:0] k;
         x[0] = key_high[63:32] ^ FK_WORDS[0];
         x[1] = key_high[31:0]  ^ FK_WORDS[1];
         x[2] = key_low[63:32]  ^ FK_WORDS[2];
         x[3] = key_low[31:0]   ^ FK_WORDS[3];
         for (int unsigned i = 0; i < NUM_ROUNDS; i++) begin
            t = subst(x[1] ^ x[2] ^ x[3] ^ ck_const(i));
            k = x[0] ^ t ^ rol(t, 13) ^ rol(t, 23);
            // decrypt just walks the same schedule backwards
            if (decrypt) begin
               round_key[NUM_ROUNDS - 1 - i] = k;
            end else begin
               round_key[i] = k;
            end
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = k;
         end
      endfunction

      function void write_reg(logic [sm4_pkg::CSR_IDX_W-1:0] index, logic [63:0] value);
         case (index)
            sm4_pkg::CSR_KEY_HIGH:     key_high = value;
            sm4_pkg::CSR_KEY_LOW:      key_low  = value;
            sm4_pkg::CSR_DECRYPT_MODE: decrypt  = value[0];
            default:                   return;
         endcase
         expand_keys();
      endfunction

      function sm4_pkg::rsp_data_type cipher_block(sm4_pkg::req_data_type blk);
         logic [31:0]           x0, x1, x2, x3, t, n;
         sm4_pkg::rsp_data_type r;
         {x0, x1} = blk.block_high;
         {x2, x3} = blk.block_low;
         for (int unsigned i = 0; i < NUM_ROUNDS; i++) begin
            t  = subst(x1 ^ x2 ^ x3 ^ round_key[i]);
            n  = x0 ^ t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
            x0 = x1;
            x1 = x2;
            x2 = x3;
            x3 = n;
         end
         r.out_high    = {x3, x2};
         r.out_low     = {x1, x0};
         r.result_last = blk.block_last;
         return r;
      endfunction

      function void note_block(sm4_pkg::req_data_type blk);
         owed_blocks.push_back(cipher_block(blk));
      endfunction

      function int unsigned pending();
         return owed_blocks.size();
      endfunction

      task report(string msg);
         $display("[%0t] ERROR: %s", $time, msg);
         mismatches++;
      endtask

      task check_block(sm4_pkg::rsp_data_type got);
         sm4_pkg::rsp_data_type want;
         if (owed_blocks.size() == 0) begin
            report($sformatf("result %h with nothing outstanding", got));
            return;
         end
         want = owed_blocks.pop_front();
         if (got.out_high !== want.out_high)
            report($sformatf("out_high %h, want %h", got.out_high, want.out_high));
         if (got.out_low !== want.out_low)
            report($sformatf("out_low %h, want %h", got.out_low, want.out_low));
         if (got.result_last !== want.result_last)
            report($sformatf("result_last %b, want %b", got.result_last, want.result_last));
      endtask
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   sm4_pkg::req_data_type req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   sm4_pkg::rsp_data_type rsp_data;
   logic                  csr_we    = 1'b0;
   logic [sm4_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0]           csr_wdata = '0;

   int unsigned  send_idle_pct = 0;
   int unsigned  recv_idle_pct = 0;
   int unsigned  holdoff_left  = 0;
   int unsigned  cycle_count   = 0;
   bit           holdoff_armed = 1'b0;
   bit           holdoff_done  = 1'b0;
   cipher_ledger ledger;

   sm4_block_cipher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // result side backpressure; a long hold-off lets the pipe fill and stall input
   always @(negedge clock) begin
      if (holdoff_armed && !holdoff_done) begin
         holdoff_done = 1'b1;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left != 0) begin
         rsp_ready <= 1'b0;
         holdoff_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end else if (!reset && rsp_valid && rsp_ready) begin
         ledger.check_block(rsp_data);
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_block(input sm4_pkg::req_data_type blk);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= blk;
      do @(posedge clock); while (!req_ready);
      ledger.note_block(blk);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [sm4_pkg::CSR_IDX_W-1:0] index,
                            input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      ledger.write_reg(index, value);
      @(negedge clock);
   endtask

   function automatic sm4_pkg::req_data_type make_block(logic [63:0] hi,
                                                        logic [63:0] lo,
                                                        logic last);
      sm4_pkg::req_data_type blk;
      blk.block_high = hi;
      blk.block_low  = lo;
      blk.block_last = last;
      return blk;
   endfunction

   function automatic logic [63:0] pick_word();
      int unsigned sel;
      sel = $urandom_range(7);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   initial begin
      ledger = new();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset key: all-zero, encrypt
      send_block(make_block('0, '0, 1'b0));
      send_block(make_block('1, '1, 1'b1));
      send_block(make_block(STD_KEY_HIGH, STD_KEY_LOW, 1'b0));
      send_block(make_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b1));

      wait_drained();
      write_csr(sm4_pkg::CSR_KEY_HIGH, STD_KEY_HIGH);
      write_csr(sm4_pkg::CSR_KEY_LOW, STD_KEY_LOW);
      send_block(make_block(STD_KEY_HIGH, STD_KEY_LOW, 1'b0));
      send_block(make_block('0, '0, 1'b0));
      send_block(make_block('1, '1, 1'b1));

      wait_drained();
      write_csr(sm4_pkg::CSR_DECRYPT_MODE, MODE_DECRYPT);
      send_block(make_block(STD_CT_HIGH, STD_CT_LOW, 1'b1));
      send_block(make_block('1, '1, 1'b0));

      // write to the unmapped index must leave the schedule alone
      wait_drained();
      write_csr(CSR_UNMAPPED, '1);
      send_block(make_block(STD_CT_HIGH, STD_CT_LOW, 1'b0));

      // only bit 0 of the mode register counts
      wait_drained();
      write_csr(sm4_pkg::CSR_DECRYPT_MODE, ~MODE_DECRYPT);
      send_block(make_block(STD_KEY_HIGH, STD_KEY_LOW, 1'b1));

      wait_drained();
      write_csr(sm4_pkg::CSR_KEY_HIGH, '1);
      write_csr(sm4_pkg::CSR_KEY_LOW, '1);
      write_csr(sm4_pkg::CSR_DECRYPT_MODE, {1'b1, 62'd0, MODE_DECRYPT[0]});
      send_block(make_block('1, '1, 1'b1));
      send_block(make_block('0, '0, 1'b0));

      for (int unsigned seg = 0; seg < NUM_SEGMENTS; seg++) begin
         wait_drained();
         if (seg < 2) begin
            send_idle_pct = 17;
            recv_idle_pct = 70;
         end else if (seg < 4) begin
            send_idle_pct = 70;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_csr(sm4_pkg::CSR_KEY_HIGH, pick_word());
         write_csr(sm4_pkg::CSR_KEY_LOW, pick_word());
         write_csr(sm4_pkg::CSR_DECRYPT_MODE, seg[0] ? MODE_DECRYPT : MODE_ENCRYPT);
         if (seg == NUM_SEGMENTS - 1) holdoff_armed = 1'b1;
         for (int unsigned n = 0; n < BLOCKS_PER_SEGMENT; n++) begin
            send_block(make_block(pick_word(), pick_word(), 1'($urandom_range(1))));
         end
      end

      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/sm4_pkg.sv
hdl/sm4_key_sched.sv
hdl/sm4_round_stage.sv
hdl/sm4_block_cipher.sv
verif/sm4_block_cipher_tb.sv
